/* hdl/dffsa_pkg.sv */
`default_nettype none
package dffsa_pkg;

  localparam logic [1:0] OP_RECORD  = 2'd0;
  localparam logic [1:0] OP_PRED    = 2'd1;
  localparam logic [1:0] OP_REQUEST = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [1:0] REASON_OK    = 2'd0;
  localparam logic [1:0] REASON_PRED  = 2'd1;
  localparam logic [1:0] REASON_NOFIT = 2'd2;

  typedef enum logic [1:0] {
    KIND_RECORD,
    KIND_PRED,
    KIND_REQUEST
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRED,
    ST_SEARCH,
    ST_MARK
  } state_t;

  // queued item, already classified
  typedef struct packed {
    kind_t              kind;
    logic [7:0]         id;
    logic signed [10:0] start;
    logic [9:0]         len;
    logic [9:0]         lo_base;
    logic               hi_neg;
    logic [10:0]        hi;
  } item_t;

  typedef struct packed {
    logic signed [10:0] start;
    logic [9:0]         len;
  } job_t;

endpackage
`default_nettype wire

/* hdl/dffsa_if.sv */
`default_nettype none
interface dffsa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [7:0]         job_id;
  logic signed [10:0] start_slot;
  logic [9:0]         length;
  logic [9:0]         release_req;
  logic [10:0]        deadline;
  logic [9:0]         now;

  modport source (output valid, operation, job_id, start_slot, length, release_req,
                  deadline, now, input ready);
  modport sink (input valid, operation, job_id, start_slot, length, release_req,
                deadline, now, output ready);
endinterface

interface dffsa_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [1:0]  reason;
  logic [9:0]  placed_start;
  logic [10:0] completion;
  logic [7:0]  request_id;

  modport source (output valid, accepted, reason, placed_start, completion, request_id,
                  input ready);
  modport sink (input valid, accepted, reason, placed_start, completion, request_id,
                output ready);
endinterface
`default_nettype wire

/* hdl/dffsa_front.sv */
`default_nettype none
module dffsa_front #(
  parameter int MAX_JOBS = 256
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  dffsa_in_if.sink             in_ch,
  output dffsa_pkg::item_t     head_o,
  output logic                 head_valid_o,
  input  wire logic            pop_i
);
  import dffsa_pkg::*;

  item_t       q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  item_t       item;
  logic        in_tab;
  logic        keep;
  logic        push;
  logic        pop;
  logic [11:0] diff;

  assign in_tab = ({24'd0, in_ch.job_id} < 32'(MAX_JOBS));
  assign keep   = (in_ch.operation == OP_PRED) || (in_ch.operation == OP_REQUEST) ||
                  ((in_ch.operation == OP_RECORD) && in_tab);
  assign in_ch.ready = (cnt_r != 2'd2);
  assign push   = in_ch.valid && in_ch.ready && keep;
  assign pop    = pop_i && (cnt_r != 2'd0);

  // latest start allowed by the deadline
  assign diff = {1'b0, in_ch.deadline} - {2'b00, in_ch.length};

  always_comb begin
    case (in_ch.operation)
      OP_RECORD: item.kind = KIND_RECORD;
      OP_PRED:   item.kind = KIND_PRED;
      default:   item.kind = KIND_REQUEST;
    endcase
    item.id      = in_ch.job_id;
    item.start   = in_ch.start_slot;
    item.len     = in_ch.length;
    item.lo_base = (in_ch.release_req > in_ch.now) ? in_ch.release_req : in_ch.now;
    item.hi_neg  = diff[11];
    item.hi      = diff[10:0];
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  assign head_o       = q_r[rd_ptr_r];
  assign head_valid_o = (cnt_r != 2'd0);

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("queue count lost a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wr_ptr_r == rd_ptr_r) else $error("queue pointers skewed");
`endif

endmodule
`default_nettype wire

/* hdl/dffsa_back.sv */
`default_nettype none
module dffsa_back #(
  parameter int HORIZON_SLOTS = 1024,
  parameter int MAX_JOBS      = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dffsa_pkg::item_t head_i,
  input  wire logic             head_valid_i,
  output logic                  pop_o,
  dffsa_out_if.source           out_ch
);
  import dffsa_pkg::*;

  localparam int PW    = $clog2(HORIZON_SLOTS);
  localparam int JW    = $clog2(MAX_JOBS);
  localparam int XW    = (PW + 1 > 12) ? PW + 1 : 12;
  localparam int CLR_N = (HORIZON_SLOTS > MAX_JOBS) ? HORIZON_SLOTS : MAX_JOBS;
  localparam int CW    = $clog2(CLR_N);

  logic   busy_mem [HORIZON_SLOTS];
  job_t   jt_mem [MAX_JOBS];
  logic   busy_rd_r;
  job_t   jt_rd_r;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  clr_r, clr_nxt;
  item_t          cur_r, cur_nxt;
  logic [XW-1:0]  p_r, p_nxt;
  logic [10:0]    run_r, run_nxt;
  logic [9:0]     cnt_r, cnt_nxt;
  logic [10:0]    pend_e_r, pend_e_nxt;
  logic           pend_f_r, pend_f_nxt;
  logic           out_v_r, out_v_nxt;
  logic           out_acc_r, out_acc_nxt;
  logic [1:0]     out_reason_r, out_reason_nxt;
  logic [9:0]     out_start_r, out_start_nxt;
  logic [10:0]    out_comp_r, out_comp_nxt;
  logic [7:0]     out_id_r, out_id_nxt;

  logic           head_in_tab, cur_in_tab;
  logic [JW-1:0]  head_idx;
  logic [10:0]    lo;
  logic [XW-1:0]  lo_x;
  logic           pre_fail;
  logic [10:0]    run_inc;
  logic           hit;
  logic [XW-1:0]  s_x, hi_x;
  logic           srch_acc, srch_fail;
  logic           last_slot;
  logic [10:0]    pred_end;
  logic           req_go;

  logic           bw_en, bw_data;
  logic [PW-1:0]  bw_addr, br_addr;
  logic           jw_en;
  logic [JW-1:0]  jw_addr, jr_addr;
  job_t           jw_data;

  assign head_in_tab = ({24'd0, head_i.id} < 32'(MAX_JOBS));
  assign cur_in_tab  = ({24'd0, cur_r.id} < 32'(MAX_JOBS));
  assign head_idx    = JW'(head_i.id);
  assign lo          = ({1'b0, head_i.lo_base} > pend_e_r) ? {1'b0, head_i.lo_base} : pend_e_r;
  assign lo_x        = XW'(lo);
  assign pre_fail    = head_i.hi_neg || (lo > head_i.hi) || (lo_x >= XW'(HORIZON_SLOTS));
  assign req_go      = head_valid_i && (head_i.kind == KIND_REQUEST) && !out_v_r;

  // one slot of the first-fit scan
  assign run_inc   = run_r + 11'd1;
  assign hit       = !busy_rd_r && (run_inc >= {1'b0, cur_r.len});
  assign s_x       = p_r + XW'(1) - XW'(cur_r.len);
  assign hi_x      = XW'(cur_r.hi);
  assign last_slot = (p_r == XW'(HORIZON_SLOTS - 1));
  assign srch_acc  = hit && (s_x <= hi_x);
  assign srch_fail = (hit && (s_x > hi_x)) ||
                     (!hit && ((busy_rd_r && (p_r >= hi_x)) || last_slot));

  assign pred_end = {1'b0, jt_rd_r.start[9:0]} +
                    ((jt_rd_r.len == 10'd0) ? 11'd1 : {1'b0, jt_rd_r.len});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (32'(clr_r) == CLR_N - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          case (head_i.kind)
            KIND_RECORD: begin
              if (!head_i.start[10]) state_nxt = ST_MARK;
            end
            KIND_PRED: begin
              if (head_in_tab) state_nxt = ST_PRED;
            end
            default: begin
              if (req_go && !pend_f_r && !pre_fail && (head_i.len != 10'd0)) begin
                state_nxt = ST_SEARCH;
              end
            end
          endcase
        end
      end
      ST_PRED:   state_nxt = ST_IDLE;
      ST_SEARCH: begin
        if (srch_acc) state_nxt = ST_MARK;
        else if (srch_fail) state_nxt = ST_IDLE;
      end
      ST_MARK: begin
        if ((cnt_r == 10'd0) || (p_r >= XW'(HORIZON_SLOTS))) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt        = clr_r;
    cur_nxt        = cur_r;
    p_nxt          = p_r;
    run_nxt        = run_r;
    cnt_nxt        = cnt_r;
    pend_e_nxt     = pend_e_r;
    pend_f_nxt     = pend_f_r;
    out_v_nxt      = out_v_r && !out_ch.ready;
    out_acc_nxt    = out_acc_r;
    out_reason_nxt = out_reason_r;
    out_start_nxt  = out_start_r;
    out_comp_nxt   = out_comp_r;
    out_id_nxt     = out_id_r;
    pop_o          = 1'b0;
    bw_en          = 1'b0;
    bw_data        = 1'b0;
    bw_addr        = p_r[PW-1:0];
    jw_en          = 1'b0;
    jw_addr        = head_idx;
    jw_data        = '{start: head_i.start, len: head_i.len};
    br_addr        = (state_r == ST_SEARCH) ? PW'(p_r + XW'(1)) : lo_x[PW-1:0];
    jr_addr        = (state_r == ST_IDLE) ? head_idx : JW'(cur_r.id);
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + CW'(1);
        bw_en   = (32'(clr_r) < HORIZON_SLOTS);
        bw_addr = clr_r[PW-1:0];
        jw_en   = (32'(clr_r) < MAX_JOBS);
        jw_addr = clr_r[JW-1:0];
        jw_data = '{start: 11'h7FF, len: 10'd0};
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          case (head_i.kind)
            KIND_RECORD: begin
              pop_o   = 1'b1;
              jw_en   = 1'b1;
              p_nxt   = XW'(head_i.start[9:0]);
              cnt_nxt = head_i.len;
            end
            KIND_PRED: begin
              pop_o   = 1'b1;
              cur_nxt = head_i;
              if (!head_in_tab) pend_f_nxt = 1'b1;
            end
            default: begin
              if (req_go) begin
                pop_o      = 1'b1;
                cur_nxt    = head_i;
                pend_e_nxt = 11'd0;
                pend_f_nxt = 1'b0;
                p_nxt      = lo_x;
                run_nxt    = 11'd0;
                out_id_nxt = head_i.id;
                if (pend_f_r) begin
                  out_v_nxt      = 1'b1;
                  out_acc_nxt    = 1'b0;
                  out_reason_nxt = REASON_PRED;
                  out_start_nxt  = 10'd0;
                  out_comp_nxt   = 11'd0;
                end else if (pre_fail) begin
                  out_v_nxt      = 1'b1;
                  out_acc_nxt    = 1'b0;
                  out_reason_nxt = REASON_NOFIT;
                  out_start_nxt  = 10'd0;
                  out_comp_nxt   = 11'd0;
                end else if (head_i.len == 10'd0) begin
                  out_v_nxt      = 1'b1;
                  out_acc_nxt    = 1'b1;
                  out_reason_nxt = REASON_OK;
                  out_start_nxt  = lo[9:0];
                  out_comp_nxt   = lo;
                  jw_en          = head_in_tab;
                  jw_data        = '{start: lo, len: 10'd0};
                end
              end
            end
          endcase
        end
      end
      ST_PRED: begin
        if (jt_rd_r.start[10]) begin
          pend_f_nxt = 1'b1;
        end else if (pred_end > pend_e_r) begin
          pend_e_nxt = pred_end;
        end
      end
      ST_SEARCH: begin
        run_nxt = busy_rd_r ? 11'd0 : run_inc;
        p_nxt   = p_r + XW'(1);
        if (srch_acc) begin
          out_v_nxt      = 1'b1;
          out_acc_nxt    = 1'b1;
          out_reason_nxt = REASON_OK;
          out_start_nxt  = s_x[9:0];
          out_comp_nxt   = s_x[10:0] + {1'b0, cur_r.len};
          jw_en          = cur_in_tab;
          jw_addr        = JW'(cur_r.id);
          jw_data        = '{start: s_x[10:0], len: cur_r.len};
          p_nxt          = s_x;
          cnt_nxt        = cur_r.len;
        end else if (srch_fail) begin
          out_v_nxt      = 1'b1;
          out_acc_nxt    = 1'b0;
          out_reason_nxt = REASON_NOFIT;
          out_start_nxt  = 10'd0;
          out_comp_nxt   = 11'd0;
        end
      end
      ST_MARK: begin
        if ((cnt_r != 10'd0) && (p_r < XW'(HORIZON_SLOTS))) begin
          bw_en   = 1'b1;
          bw_data = 1'b1;
          p_nxt   = p_r + XW'(1);
          cnt_nxt = cnt_r - 10'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      pend_e_r <= 11'd0;
      pend_f_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      pend_e_r <= pend_e_nxt;
      pend_f_r <= pend_f_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    p_r          <= p_nxt;
    run_r        <= run_nxt;
    cnt_r        <= cnt_nxt;
    out_acc_r    <= out_acc_nxt;
    out_reason_r <= out_reason_nxt;
    out_start_r  <= out_start_nxt;
    out_comp_r   <= out_comp_nxt;
    out_id_r     <= out_id_nxt;
  end

  always_ff @(posedge clk) begin
    if (bw_en) begin
      busy_mem[bw_addr] <= bw_data;
    end
    busy_rd_r <= busy_mem[br_addr];
  end

  always_ff @(posedge clk) begin
    if (jw_en) begin
      jt_mem[jw_addr] <= jw_data;
    end
    jt_rd_r <= jt_mem[jr_addr];
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.accepted     = out_acc_r;
  assign out_ch.reason       = out_reason_r;
  assign out_ch.placed_start = out_start_r;
  assign out_ch.completion   = out_comp_r;
  assign out_ch.request_id   = out_id_r;

`ifndef ASSERT_OFF
  a_scan_in_horizon: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH |-> p_r < XW'(HORIZON_SLOTS)) else $error("scan past horizon");
  a_reason_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_acc_r == (out_reason_r == REASON_OK))) else $error("reason mismatch");
  a_pending_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> (pend_e_r == 11'd0) && !pend_f_r) else $error("pending not cleared");
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(state_r == ST_IDLE || state_r == ST_SEARCH))
    else $error("result from wrong state");
`endif

endmodule
`default_nettype wire

/* hdl/deadline_first_fit_slot_allocator.sv */
`default_nettype none
// operation: a record writes the job table and marks its length slots; a predecessor
//   reads the job table; a request is settled up front, or else scans one busy-map
//   slot per cycle, and marking the length slots of a placed request follows while
//   its result waits or leaves; the back end takes one item at a time
// reset: synchronous active low; then the busy map and job table are cleared, and
//   during that clearing items only queue up
module deadline_first_fit_slot_allocator #(
  parameter int HORIZON_SLOTS = 1024,
  parameter int MAX_JOBS      = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dffsa_in_if.sink      in_ch,
  dffsa_out_if.source   out_ch
);
  import dffsa_pkg::*;

  item_t head;
  logic  head_valid;
  logic  pop;

  dffsa_front #(
    .MAX_JOBS(MAX_JOBS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .head_o      (head),
    .head_valid_o(head_valid),
    .pop_i       (pop)
  );

  dffsa_back #(
    .HORIZON_SLOTS(HORIZON_SLOTS),
    .MAX_JOBS     (MAX_JOBS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_i      (head),
    .head_valid_i(head_valid),
    .pop_o       (pop),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire
